// ===== hdl/tgp_pkg.sv =====
// Package for the turtle grid plotter: grid geometry, command and heading
// codes, and the queue entry type. No dependencies.
`default_nettype none

package tgp_pkg;

    localparam int ROWS     = 32;
    localparam int COLS     = 32;
    localparam int EMIT_MAX = 32;
    localparam int EMIT_N   = (ROWS < EMIT_MAX) ? ROWS : EMIT_MAX;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int MODE_W = 3;
    localparam int STEP_W = 8;
    localparam int IDX_W  = 5;
    localparam int BITS_W = 32;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [MODE_W-1:0] MODE_PEN_UP   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PEN_DOWN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TURN_R   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TURN_L   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PRINT    = 3'd5;

    typedef enum logic [2:0] {
        CMD_PEN_UP,
        CMD_PEN_DOWN,
        CMD_TURN_R,
        CMD_TURN_L,
        CMD_MOVE,
        CMD_PRINT
    } t_cmd;

    typedef enum logic [1:0] {
        HD_RIGHT,
        HD_DOWN,
        HD_LEFT,
        HD_UP
    } t_heading;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_PRINT
    } t_state;

    typedef struct packed {
        t_cmd              op;
        logic [STEP_W-1:0] steps;
    } t_cmd_item;

endpackage

`default_nettype wire

// ===== hdl/tgp_if.sv =====
// Channel interfaces of the turtle grid plotter: command input and row output.
// Depends on tgp_pkg for field widths.
`default_nettype none

interface tgp_in_if;
    logic                        valid;
    logic                        ready;
    logic [tgp_pkg::MODE_W-1:0]  mode;
    logic [tgp_pkg::STEP_W-1:0]  steps;

    modport source (output valid, output mode, output steps, input ready);
    modport sink   (input valid, input mode, input steps, output ready);
endinterface

interface tgp_out_if;
    logic                        valid;
    logic                        ready;
    logic [tgp_pkg::IDX_W-1:0]   row_index;
    logic [tgp_pkg::BITS_W-1:0]  row_bits;
    logic                        last_row;

    modport source (output valid, output row_index, output row_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input row_bits, input last_row,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/turtle_grid_plotter_top.sv =====
// Top level of the turtle grid plotter: front end, command queue, back end.
// Depends on tgp_pkg, tgp_if, tgp_front, tgp_fifo and tgp_back.
//
// Usage:
//   i_cmd carries one command per transaction (mode, steps). o_row carries
//   the rows of a print, row 0 first, last_row set on the final row.
//   Commands enter a four-entry queue; the input stalls only when it is full.
//   Pen up, pen down and turns complete as they leave the queue. A move
//   leaves the queue, then the back end steps it cell by cell, only for the
//   cells left after clipping at the grid edge.
//   Moves of zero steps and unused modes are dropped at the input.
//   A print reads the grid memory one row per cycle, while the receiver does
//   not stall, through a registered read stage and an output register, and
//   always emits all 32 rows of the grid.
//   When the receiver stalls, the output register and read stage hold and
//   the row sequencer pauses; later commands wait in the queue.
//   Reset clears position, heading (right), pen, queue and the row valid
//   bits, so the grid reads as all zero at once with no clearing pass.
`default_nettype none

module turtle_grid_plotter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgp_in_if.sink     i_cmd,
    tgp_out_if.source  o_row
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    tgp_pkg::t_cmd_item  q_in_item;
    tgp_pkg::t_cmd_item  q_out_item;

    tgp_front u_front (
        .i_cmd  (i_cmd),
        .i_full (q_full),
        .o_push (q_push),
        .o_item (q_in_item)
    );

    tgp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    tgp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_out_item),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_row   (o_row)
    );

endmodule

`default_nettype wire

// ===== hdl/tgp_front.sv =====
// Front end: accepts command transactions, decodes the mode and drops
// commands without effect. Depends on tgp_pkg and tgp_in_if.
`default_nettype none

module tgp_front (
    tgp_in_if.sink              i_cmd,
    input  logic                i_full,
    output logic                o_push,
    output tgp_pkg::t_cmd_item  o_item
);

    logic keep;

    assign i_cmd.ready = !i_full;

    always_comb begin
        o_item.steps = i_cmd.steps;
        o_item.op    = tgp_pkg::CMD_PEN_UP;
        keep         = 1'b1;
        case (i_cmd.mode)
            tgp_pkg::MODE_PEN_UP:   o_item.op = tgp_pkg::CMD_PEN_UP;
            tgp_pkg::MODE_PEN_DOWN: o_item.op = tgp_pkg::CMD_PEN_DOWN;
            tgp_pkg::MODE_TURN_R:   o_item.op = tgp_pkg::CMD_TURN_R;
            tgp_pkg::MODE_TURN_L:   o_item.op = tgp_pkg::CMD_TURN_L;
            tgp_pkg::MODE_MOVE: begin
                o_item.op = tgp_pkg::CMD_MOVE;
                keep      = (i_cmd.steps != '0);
            end
            tgp_pkg::MODE_PRINT:    o_item.op = tgp_pkg::CMD_PRINT;
            default:                keep = 1'b0;
        endcase
    end

    assign o_push = i_cmd.valid && !i_full && keep;

endmodule

`default_nettype wire

// ===== hdl/tgp_fifo.sv =====
// Short command queue between front and back end.
// Depends on tgp_pkg for the entry type and depth.
`default_nettype none

module tgp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgp_pkg::t_cmd_item  i_item,
    output logic                o_full,
    input  logic                i_pop,
    output tgp_pkg::t_cmd_item  o_item,
    output logic                o_empty
);

    tgp_pkg::t_cmd_item          r_mem [tgp_pkg::QDEPTH];
    logic [tgp_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tgp_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tgp_pkg::QPTR_W:0]    r_cnt;
    logic [tgp_pkg::QPTR_W:0]    n_cnt;

    assign o_full  = (r_cnt == (tgp_pkg::QPTR_W+1)'(tgp_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (tgp_pkg::QPTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (tgp_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tgp_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tgp_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tgp_back.sv =====
// Back end: turtle state, grid memory with row valid bits, move sequencer
// and print pipeline. Depends on tgp_pkg and tgp_out_if.
`default_nettype none

module tgp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgp_pkg::t_cmd_item  i_item,
    input  logic                i_empty,
    output logic                o_pop,
    tgp_out_if.source           o_row
);

    localparam logic [tgp_pkg::ROW_W-1:0] ROW_LAST = tgp_pkg::ROW_W'(tgp_pkg::ROWS - 1);
    localparam logic [tgp_pkg::COL_W-1:0] COL_LAST = tgp_pkg::COL_W'(tgp_pkg::COLS - 1);
    localparam logic [tgp_pkg::ROW_W-1:0] PR_LAST  = tgp_pkg::ROW_W'(tgp_pkg::EMIT_N - 1);
    localparam logic [tgp_pkg::COLS-1:0]  BIT_ONE  = tgp_pkg::COLS'(1);

    tgp_pkg::t_state              r_state, n_state;
    tgp_pkg::t_heading            r_heading, n_heading;
    logic [tgp_pkg::ROW_W-1:0]    r_pos_row, n_pos_row;
    logic [tgp_pkg::COL_W-1:0]    r_pos_col, n_pos_col;
    logic                         r_pen, n_pen;
    logic [tgp_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic [tgp_pkg::ROW_W-1:0]    r_pr_idx, n_pr_idx;

    logic [tgp_pkg::COLS-1:0]     r_mem [tgp_pkg::ROWS];
    logic [tgp_pkg::ROWS-1:0]     r_row_vld;

    logic                         wr_en;
    logic [tgp_pkg::ROW_W-1:0]    wr_row;
    logic [tgp_pkg::COL_W-1:0]    wr_col;
    logic [tgp_pkg::COLS-1:0]     wr_bit;
    logic [tgp_pkg::COLS-1:0]     wr_mask;
    logic                         rd_en;
    logic [tgp_pkg::ROW_W-1:0]    rd_row;

    logic                         r_a_vld;
    logic [tgp_pkg::ROW_W-1:0]    r_a_row;
    logic                         r_a_last;
    logic                         r_a_ok;
    logic [tgp_pkg::COLS-1:0]     r_a_data;

    logic                         r_b_vld;
    logic [tgp_pkg::ROW_W-1:0]    r_b_row;
    logic                         r_b_last;
    logic [tgp_pkg::BITS_W-1:0]   r_b_bits;

    logic                         b_take;
    logic                         b_free;
    logic                         a_move;
    logic                         a_free;

    logic [tgp_pkg::STEP_W-1:0]   room;
    logic [tgp_pkg::STEP_W-1:0]   clip;
    logic [tgp_pkg::ROW_W-1:0]    stp_row;
    logic [tgp_pkg::COL_W-1:0]    stp_col;

    assign b_take = r_b_vld && o_row.ready;
    assign b_free = !r_b_vld || b_take;
    assign a_move = r_a_vld && b_free;
    assign a_free = !r_a_vld || a_move;

    assign o_row.valid     = r_b_vld;
    assign o_row.row_index = tgp_pkg::IDX_W'(r_b_row);
    assign o_row.row_bits  = r_b_bits;
    assign o_row.last_row  = r_b_last;

    assign wr_bit  = BIT_ONE << wr_col;
    assign wr_mask = r_row_vld[wr_row] ? wr_bit : '1;

    // distance to the edge in the current heading, then clip the move
    always_comb begin
        case (r_heading)
            tgp_pkg::HD_RIGHT: room = tgp_pkg::STEP_W'(COL_LAST - r_pos_col);
            tgp_pkg::HD_DOWN:  room = tgp_pkg::STEP_W'(ROW_LAST - r_pos_row);
            tgp_pkg::HD_LEFT:  room = tgp_pkg::STEP_W'(r_pos_col);
            default:           room = tgp_pkg::STEP_W'(r_pos_row);
        endcase
        clip = (i_item.steps > room) ? room : i_item.steps;
    end

    always_comb begin
        stp_row = r_pos_row;
        stp_col = r_pos_col;
        case (r_heading)
            tgp_pkg::HD_RIGHT: stp_col = r_pos_col + tgp_pkg::COL_W'(1);
            tgp_pkg::HD_DOWN:  stp_row = r_pos_row + tgp_pkg::ROW_W'(1);
            tgp_pkg::HD_LEFT:  stp_col = r_pos_col - tgp_pkg::COL_W'(1);
            default:           stp_row = r_pos_row - tgp_pkg::ROW_W'(1);
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_heading = r_heading;
        n_pos_row = r_pos_row;
        n_pos_col = r_pos_col;
        n_pen     = r_pen;
        n_cnt     = r_cnt;
        n_pr_idx  = r_pr_idx;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        wr_row    = r_pos_row;
        wr_col    = r_pos_col;
        rd_en     = 1'b0;
        rd_row    = r_pr_idx;
        case (r_state)
            tgp_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        tgp_pkg::CMD_PEN_UP:   n_pen = 1'b0;
                        tgp_pkg::CMD_PEN_DOWN: begin
                            n_pen = 1'b1;
                            wr_en = 1'b1;
                        end
                        tgp_pkg::CMD_TURN_R:
                            n_heading = tgp_pkg::t_heading'(r_heading + 2'd1);
                        tgp_pkg::CMD_TURN_L:
                            n_heading = tgp_pkg::t_heading'(r_heading + 2'd3);
                        tgp_pkg::CMD_MOVE: begin
                            if (clip != '0) begin
                                n_cnt   = clip;
                                n_state = tgp_pkg::ST_MOVE;
                            end
                        end
                        tgp_pkg::CMD_PRINT: begin
                            n_pr_idx = '0;
                            n_state  = tgp_pkg::ST_PRINT;
                        end
                        default: ;
                    endcase
                end
            end
            tgp_pkg::ST_MOVE: begin
                n_pos_row = stp_row;
                n_pos_col = stp_col;
                wr_en     = r_pen;
                wr_row    = stp_row;
                wr_col    = stp_col;
                n_cnt     = r_cnt - tgp_pkg::STEP_W'(1);
                if (r_cnt == tgp_pkg::STEP_W'(1)) begin
                    n_state = tgp_pkg::ST_IDLE;
                end
            end
            tgp_pkg::ST_PRINT: begin
                if (a_free) begin
                    rd_en    = 1'b1;
                    n_pr_idx = r_pr_idx + tgp_pkg::ROW_W'(1);
                    if (r_pr_idx == PR_LAST) begin
                        n_pr_idx = '0;
                        n_state  = tgp_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = tgp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tgp_pkg::ST_IDLE;
            r_heading <= tgp_pkg::HD_RIGHT;
            r_pos_row <= '0;
            r_pos_col <= '0;
            r_pen     <= 1'b0;
            r_cnt     <= '0;
            r_pr_idx  <= '0;
            r_row_vld <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_heading <= n_heading;
            r_pos_row <= n_pos_row;
            r_pos_col <= n_pos_col;
            r_pen     <= n_pen;
            r_cnt     <= n_cnt;
            r_pr_idx  <= n_pr_idx;
            if (wr_en) begin
                r_row_vld[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (b_take) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int c = 0; c < tgp_pkg::COLS; c++) begin
                if (wr_mask[c]) begin
                    r_mem[wr_row][c] <= wr_bit[c];
                end
            end
        end
        if (rd_en) begin
            r_a_data <= r_mem[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a_row  <= rd_row;
            r_a_last <= (rd_row == PR_LAST);
            r_a_ok   <= r_row_vld[rd_row];
        end
        if (a_move) begin
            r_b_row  <= r_a_row;
            r_b_last <= r_a_last;
            r_b_bits <= r_a_ok ? tgp_pkg::BITS_W'(r_a_data) : '0;
        end
    end

    a_move_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgp_pkg::ST_MOVE) |-> (r_cnt != '0))
        else $error("move sequencer active with zero steps left");

    a_no_write_in_print : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgp_pkg::ST_PRINT) |-> !wr_en)
        else $error("grid written during print");

    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.last_row) |-> (r_b_row == PR_LAST))
        else $error("last row flag on wrong row");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos_row <= ROW_LAST) && (r_pos_col <= COL_LAST))
        else $error("turtle outside the grid");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
